/* rtl/i2cm_pkg.sv */
// Shared types, phase codes and command codes of the I2C master byte engine.
package i2cm_pkg;

   localparam int UnitW  = 12;
   localparam int WaitW  = 14;
   localparam int PhaseW = 4;
   localparam int CountW = 4;

   localparam logic [2:0] CMD_TICK  = 3'd0;
   localparam logic [2:0] CMD_START = 3'd1;
   localparam logic [2:0] CMD_STOP  = 3'd2;
   localparam logic [2:0] CMD_SEND  = 3'd3;
   localparam logic [2:0] CMD_RECV  = 3'd4;
   localparam logic [2:0] CMD_ACKC  = 3'd5;
   localparam logic [2:0] CMD_ACKS  = 3'd6;
   localparam logic [2:0] CMD_NACK  = 3'd7;

   localparam logic [PhaseW-1:0] PH_IDLE    = 4'd0;
   localparam logic [PhaseW-1:0] PH_START_A = 4'd1;
   localparam logic [PhaseW-1:0] PH_START_B = 4'd2;
   localparam logic [PhaseW-1:0] PH_STOP_A  = 4'd3;
   localparam logic [PhaseW-1:0] PH_SEND_HI = 4'd4;
   localparam logic [PhaseW-1:0] PH_SEND_LO = 4'd5;
   localparam logic [PhaseW-1:0] PH_RCV_LO  = 4'd6;
   localparam logic [PhaseW-1:0] PH_RCV_HI  = 4'd7;
   localparam logic [PhaseW-1:0] PH_ACKC_HI = 4'd8;
   localparam logic [PhaseW-1:0] PH_ACKS_LO = 4'd9;
   localparam logic [PhaseW-1:0] PH_ACKS_HI = 4'd10;
   localparam logic [PhaseW-1:0] PH_NACK_HI = 4'd11;
   localparam logic [PhaseW-1:0] PH_NACK_LO = 4'd12;

   localparam logic [CountW-1:0] BITS_PER_BYTE = 4'd8;

   typedef struct packed {
      logic [PhaseW-1:0] phase;
      logic [CountW-1:0] bit_count;
      logic [7:0]        shift_reg;
      logic [WaitW-1:0]  wait_count;
      logic              scl_drive;
      logic              scl_level;
      logic              sda_drive;
      logic              sda_level;
      logic [7:0]        rx_hold;
      logic              ack_hold;
   } engine_state_type;

   typedef struct packed {
      logic       scl_drive;
      logic       scl_level;
      logic       sda_drive;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] rx_byte;
      logic       ack_bit;
      logic       cmd_rejected;
   } rsp_word_type;

endpackage

/* rtl/i2cm_if.sv */
// Channel interfaces: command word in, result word out, and the unit_ticks write port.
interface i2cm_req_if;
   import i2cm_pkg::*;
   logic       valid;
   logic       ready;
   logic [2:0] cmd;
   logic [7:0] tx_byte;
   logic       sda_in;
   modport source (output valid, cmd, tx_byte, sda_in, input ready);
   modport sink   (input valid, cmd, tx_byte, sda_in, output ready);
endinterface

interface i2cm_rsp_if;
   import i2cm_pkg::*;
   logic       valid;
   logic       ready;
   logic       scl_drive;
   logic       scl_level;
   logic       sda_drive;
   logic       sda_level;
   logic       busy_res;
   logic       done_res;
   logic [7:0] rx_byte;
   logic       ack_bit;
   logic       cmd_rejected;
   modport source (output valid, scl_drive, scl_level, sda_drive, sda_level, busy_res,
                   done_res, rx_byte, ack_bit, cmd_rejected, input ready);
   modport sink   (input valid, scl_drive, scl_level, sda_drive, sda_level, busy_res,
                   done_res, rx_byte, ack_bit, cmd_rejected, output ready);
endinterface

interface i2cm_csr_if;
   import i2cm_pkg::*;
   logic             valid;
   logic             ready;
   logic [UnitW-1:0] unit_ticks;
   modport source (output valid, unit_ticks, input ready);
   modport sink   (input valid, unit_ticks, output ready);
endinterface

/* rtl/i2cm_step.sv */
// Next-state and result logic for one command or tick word.
module i2cm_step (
   input  i2cm_pkg::engine_state_type    cur,
   input  logic [2:0]                    cmd,
   input  logic [7:0]                    tx_byte,
   input  logic                          sda_in,
   input  logic [i2cm_pkg::UnitW-1:0]    unit_ticks,
   output i2cm_pkg::engine_state_type    nxt,
   output i2cm_pkg::rsp_word_type        rsp
);
   import i2cm_pkg::*;

   logic [UnitW-1:0]  unit_eff;
   logic [WaitW-1:0]  wait1, wait2, wait3, wait4;
   logic [CountW-1:0] bit_dec;
   logic [7:0]        rx_shift;
   logic              done;
   logic              rejected;

   // A unit of zero ticks behaves as one tick.
   assign unit_eff = (unit_ticks == '0) ? UnitW'(1) : unit_ticks;
   assign wait1    = WaitW'(unit_eff);
   assign wait2    = WaitW'(unit_eff) << 1;
   assign wait4    = WaitW'(unit_eff) << 2;
   assign wait3    = wait1 + wait2;
   assign bit_dec  = cur.bit_count - CountW'(1);
   assign rx_shift = {cur.shift_reg[6:0], sda_in};

   always_comb begin
      nxt      = cur;
      done     = 1'b0;
      rejected = 1'b0;
      if (cur.phase != PH_IDLE) begin
         if (cmd != CMD_TICK) begin
            rejected = 1'b1;
         end else if (cur.wait_count > WaitW'(1)) begin
            nxt.wait_count = cur.wait_count - WaitW'(1);
         end else begin
            // Ending action of the current phase; finishing arms go back to idle.
            done           = 1'b1;
            nxt.phase      = PH_IDLE;
            nxt.wait_count = '0;
            unique case (cur.phase)
               PH_START_A: begin
                  nxt.sda_level  = 1'b0;
                  nxt.phase      = PH_START_B;
                  nxt.wait_count = wait2;
                  done           = 1'b0;
               end
               PH_START_B: begin
                  nxt.scl_level = 1'b0;
               end
               PH_STOP_A: begin
                  nxt.sda_drive = 1'b0;
                  nxt.scl_drive = 1'b0;
               end
               PH_SEND_HI: begin
                  nxt.scl_level  = 1'b0;
                  nxt.phase      = PH_SEND_LO;
                  nxt.wait_count = wait3;
                  done           = 1'b0;
               end
               PH_SEND_LO: begin
                  nxt.bit_count = bit_dec;
                  if (bit_dec != '0) begin
                     nxt.sda_level  = cur.shift_reg[7];
                     nxt.shift_reg  = {cur.shift_reg[6:0], 1'b0};
                     nxt.scl_level  = 1'b1;
                     nxt.phase      = PH_SEND_HI;
                     nxt.wait_count = wait4;
                     done           = 1'b0;
                  end else begin
                     nxt.sda_drive = 1'b0;
                  end
               end
               PH_RCV_LO: begin
                  nxt.scl_level  = 1'b1;
                  nxt.phase      = PH_RCV_HI;
                  nxt.wait_count = WaitW'(1);
                  done           = 1'b0;
               end
               PH_RCV_HI: begin
                  nxt.shift_reg = rx_shift;
                  nxt.scl_level = 1'b0;
                  nxt.bit_count = bit_dec;
                  if (bit_dec != '0) begin
                     nxt.phase      = PH_RCV_LO;
                     nxt.wait_count = wait1;
                     done           = 1'b0;
                  end else begin
                     nxt.rx_hold = rx_shift;
                  end
               end
               PH_ACKC_HI: begin
                  nxt.ack_hold  = sda_in;
                  nxt.scl_level = 1'b0;
               end
               PH_ACKS_LO: begin
                  nxt.scl_level  = 1'b1;
                  nxt.phase      = PH_ACKS_HI;
                  nxt.wait_count = wait2;
                  done           = 1'b0;
               end
               PH_ACKS_HI: begin
                  nxt.scl_level = 1'b0;
                  nxt.sda_drive = 1'b0;
               end
               PH_NACK_HI: begin
                  nxt.scl_level  = 1'b0;
                  nxt.phase      = PH_NACK_LO;
                  nxt.wait_count = wait1;
                  done           = 1'b0;
               end
               PH_NACK_LO: begin
                  nxt.sda_drive = 1'b0;
               end
               default: begin
               end
            endcase
         end
      end else begin
         unique case (cmd)
            CMD_START: begin
               nxt.sda_drive  = 1'b1;
               nxt.sda_level  = 1'b1;
               nxt.scl_drive  = 1'b1;
               nxt.scl_level  = 1'b1;
               nxt.phase      = PH_START_A;
               nxt.wait_count = wait2;
            end
            CMD_STOP: begin
               nxt.sda_drive  = 1'b1;
               nxt.sda_level  = 1'b0;
               nxt.scl_drive  = 1'b1;
               nxt.scl_level  = 1'b1;
               nxt.phase      = PH_STOP_A;
               nxt.wait_count = wait2;
            end
            CMD_SEND: begin
               // The first bit goes out at once; the rest follow each low phase.
               nxt.sda_drive  = 1'b1;
               nxt.scl_drive  = 1'b1;
               nxt.sda_level  = tx_byte[7];
               nxt.shift_reg  = {tx_byte[6:0], 1'b0};
               nxt.bit_count  = BITS_PER_BYTE;
               nxt.scl_level  = 1'b1;
               nxt.phase      = PH_SEND_HI;
               nxt.wait_count = wait4;
            end
            CMD_RECV: begin
               nxt.sda_drive  = 1'b0;
               nxt.scl_drive  = 1'b1;
               nxt.bit_count  = BITS_PER_BYTE;
               nxt.phase      = PH_RCV_LO;
               nxt.wait_count = wait1;
            end
            CMD_ACKC: begin
               nxt.sda_drive  = 1'b0;
               nxt.scl_drive  = 1'b1;
               nxt.scl_level  = 1'b1;
               nxt.phase      = PH_ACKC_HI;
               nxt.wait_count = wait1;
            end
            CMD_ACKS: begin
               nxt.sda_drive  = 1'b1;
               nxt.sda_level  = 1'b0;
               nxt.scl_drive  = 1'b1;
               nxt.phase      = PH_ACKS_LO;
               nxt.wait_count = wait1;
            end
            CMD_NACK: begin
               nxt.sda_drive  = 1'b1;
               nxt.sda_level  = 1'b1;
               nxt.scl_drive  = 1'b1;
               nxt.scl_level  = 1'b1;
               nxt.phase      = PH_NACK_HI;
               nxt.wait_count = wait1;
            end
            CMD_TICK: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      rsp.scl_drive    = nxt.scl_drive;
      rsp.scl_level    = nxt.scl_level;
      rsp.sda_drive    = nxt.sda_drive;
      rsp.sda_level    = nxt.sda_level;
      rsp.busy_res     = (nxt.phase != PH_IDLE);
      rsp.done_res     = done;
      rsp.rx_byte      = nxt.rx_hold;
      rsp.ack_bit      = nxt.ack_hold;
      rsp.cmd_rejected = rejected;
   end

endmodule

/* rtl/i2cm_rsp_stage.sv */
// Result register: holds one result word until the sink takes it.
module i2cm_rsp_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  i2cm_pkg::rsp_word_type word_in,
   output logic                   can_load,
   i2cm_rsp_if.source             rsp_ch
);
   import i2cm_pkg::*;

   logic         valid_ff;
   logic         valid_in;
   rsp_word_type word_ff;

   // A new word may enter when the register is empty or is drained this cycle.
   assign can_load = !valid_ff || rsp_ch.ready;
   assign valid_in = load || (valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         word_ff <= word_in;
      end
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.scl_drive    = word_ff.scl_drive;
   assign rsp_ch.scl_level    = word_ff.scl_level;
   assign rsp_ch.sda_drive    = word_ff.sda_drive;
   assign rsp_ch.sda_level    = word_ff.sda_level;
   assign rsp_ch.busy_res     = word_ff.busy_res;
   assign rsp_ch.done_res     = word_ff.done_res;
   assign rsp_ch.rx_byte      = word_ff.rx_byte;
   assign rsp_ch.ack_bit      = word_ff.ack_bit;
   assign rsp_ch.cmd_rejected = word_ff.cmd_rejected;

endmodule

/* rtl/i2c_master_byte_engine_unit.sv */
// Top level of the I2C master byte engine: engine state, unit register, result stage.
//
//   channel   dir   contents
//   req_ch    in    cmd, tx_byte, sda_in
//   rsp_ch    out   pin drives and levels, busy, done, rx_byte, ack_bit, cmd_rejected
//   csr_ch    in    unit_ticks
//
// Every accepted word updates the engine state and puts one result word in the result
// register at the same clock edge, so one word is taken per clock.
// The rate is set by the single result register: a word is taken whenever that
// register is empty or is being drained. A stall on rsp_ch holds req_ch off.
// Synchronous reset releases both lines (latched levels high) and sets unit_ticks to 1.
module i2c_master_byte_engine_unit (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch,
   i2cm_csr_if.sink   csr_ch
);
   import i2cm_pkg::*;

   engine_state_type state_ff;
   engine_state_type state_in;
   rsp_word_type     rsp_word;
   logic [UnitW-1:0] unit_ff;
   logic             can_load;
   logic             req_fire;

   assign req_ch.ready = can_load;
   assign req_fire     = req_ch.valid && can_load;
   assign csr_ch.ready = 1'b1;

   i2cm_step u_step (
      .cur        (state_ff),
      .cmd        (req_ch.cmd),
      .tx_byte    (req_ch.tx_byte),
      .sda_in     (req_ch.sda_in),
      .unit_ticks (unit_ff),
      .nxt        (state_in),
      .rsp        (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UnitW'(1);
      end else if (csr_ch.valid) begin
         unit_ff <= csr_ch.unit_ticks;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.phase      <= PH_IDLE;
         state_ff.bit_count  <= '0;
         state_ff.shift_reg  <= '0;
         state_ff.wait_count <= '0;
         state_ff.scl_drive  <= 1'b0;
         state_ff.scl_level  <= 1'b1;
         state_ff.sda_drive  <= 1'b0;
         state_ff.sda_level  <= 1'b1;
         state_ff.rx_hold    <= '0;
         state_ff.ack_hold   <= 1'b1;
      end else if (req_fire) begin
         state_ff <= state_in;
      end
   end

   i2cm_rsp_stage u_rsp_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (req_fire),
      .word_in  (rsp_word),
      .can_load (can_load),
      .rsp_ch   (rsp_ch)
   );

endmodule
